// ===== src/pwc_pkg.sv =====
// pwc_pkg: shared types, constants and arithmetic helpers for the particle step block
// used by the channel interfaces, the store, the iterative unit, the top level and the checker
package pwc_pkg;

   localparam int PWC_NUM_PARTICLES = 64;
   localparam int IDX_W             = 6;
   localparam int CMD_W             = 2;
   localparam int FIX_W             = 32;
   localparam int MR_W              = 31;
   localparam int AREA_W            = 16;
   localparam int CSR_IDX_W         = 1;
   localparam int CSR_DATA_W        = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_AREA_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_AREA_HEIGHT = 1'b1;

   localparam logic [AREA_W-1:0] AREA_WIDTH_RESET  = 16'd800;
   localparam logic [AREA_W-1:0] AREA_HEIGHT_RESET = 16'd600;

   localparam logic signed [39:0] FIX_ONE = 40'sd65536;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD    = 2'd0,
      CMD_MOVE    = 2'd1,
      CMD_COLLIDE = 2'd2,
      CMD_READ    = 2'd3
   } pwc_cmd_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_LOAD, ST_RDA, ST_RDB, ST_CAPB, ST_MOVE, ST_DIFF, ST_SQX, ST_SQY,
      ST_SUM, ST_SQRT, ST_QA_GO, ST_QA, ST_QB_GO, ST_QB, ST_M1, ST_M2, ST_M3, ST_M4,
      ST_M5, ST_M6, ST_OX_GO, ST_OX, ST_OY_GO, ST_OY, ST_WRA, ST_WRB, ST_EA, ST_EB
   } pwc_state_type;

   typedef enum logic {
      ITER_SQRT = 1'b0,
      ITER_DIV  = 1'b1
   } pwc_iter_mode_type;

   typedef struct packed {
      logic              start;
      pwc_iter_mode_type mode;
      logic [63:0]       operand;
      logic [32:0]       divisor;
   } pwc_iter_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] result;
   } pwc_iter_rsp_type;

   typedef struct packed {
      logic wr_pv;
      logic wr_mr;
   } pwc_mem_ctl_type;

   typedef struct packed {
      logic [63:0] pos;
      logic [63:0] vel;
      logic [63:0] mr;
   } pwc_entry_type;

   // index reduction modulo the table depth, six conditional subtracts
   function automatic logic [IDX_W-1:0] pwc_mod_index(input logic [IDX_W-1:0] v,
                                                      input int unsigned n);
      logic [31:0] rem;
      logic [31:0] sub;
      rem = 32'(v);
      for (int k = IDX_W - 1; k >= 0; k--) begin
         sub = 32'(n) << k;
         if (sub <= rem) begin
            rem = rem - sub;
         end
      end
      return rem[IDX_W-1:0];
   endfunction

   function automatic logic signed [31:0] pwc_sat32(input logic signed [39:0] v);
      logic signed [31:0] r;
      if (v > 40'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -40'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // move along one axis and bounce off the walls, returns {velocity, position}
   function automatic logic [63:0] pwc_bounce(input logic signed [31:0] p,
                                              input logic signed [31:0] v,
                                              input logic [MR_W-1:0] r,
                                              input logic [AREA_W-1:0] area);
      logic signed [39:0] np;
      logic signed [39:0] rr;
      logic signed [39:0] wall;
      logic signed [39:0] nv;
      logic signed [39:0] pp;
      np   = 40'(p) + 40'(v);
      rr   = signed'({9'b0, r});
      wall = signed'({8'b0, area, 16'b0});
      nv   = 40'(v);
      pp   = np;
      if (np + rr >= wall) begin
         nv = -40'(v);
         pp = wall - rr - FIX_ONE;
      end else if (np - rr <= 40'sd0) begin
         nv = -40'(v);
         pp = rr + FIX_ONE;
      end
      return {pwc_sat32(nv), pwc_sat32(pp)};
   endfunction

   // base plus or minus a magnitude, saturated
   function automatic logic signed [31:0] pwc_adj(input logic signed [31:0] base,
                                                  input logic neg,
                                                  input logic [33:0] m);
      logic signed [39:0] s;
      s = signed'({6'b0, m});
      if (neg) begin
         s = -s;
      end
      return pwc_sat32(40'(base) + s);
   endfunction

   function automatic logic [33:0] pwc_clamp34(input logic [63:0] q);
      return (|q[63:34]) ? '1 : q[33:0];
   endfunction

endpackage

// ===== src/pwc_req_if.sv =====
// pwc_req_if: request channel of the particle step block
// depends on pwc_pkg for field widths
interface pwc_req_if;
   import pwc_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [CMD_W-1:0]        cmd;
   logic [IDX_W-1:0]        first_index;
   logic [IDX_W-1:0]        second_index;
   logic signed [FIX_W-1:0] load_pos_x;
   logic signed [FIX_W-1:0] load_pos_y;
   logic signed [FIX_W-1:0] load_vel_x;
   logic signed [FIX_W-1:0] load_vel_y;
   logic [MR_W-1:0]         load_mass;
   logic [MR_W-1:0]         load_radius;

   modport source (output valid, cmd, first_index, second_index, load_pos_x, load_pos_y,
                   load_vel_x, load_vel_y, load_mass, load_radius, input ready);
   modport sink (input valid, cmd, first_index, second_index, load_pos_x, load_pos_y,
                 load_vel_x, load_vel_y, load_mass, load_radius, output ready);
endinterface

// ===== src/pwc_rsp_if.sv =====
// pwc_rsp_if: result channel of the particle step block
// depends on pwc_pkg for field widths
interface pwc_rsp_if;
   import pwc_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [IDX_W-1:0]        entry_index;
   logic signed [FIX_W-1:0] out_pos_x;
   logic signed [FIX_W-1:0] out_pos_y;
   logic signed [FIX_W-1:0] out_vel_x;
   logic signed [FIX_W-1:0] out_vel_y;
   logic                    collided;
   logic                    last_result;

   modport source (output valid, entry_index, out_pos_x, out_pos_y, out_vel_x, out_vel_y,
                   collided, last_result, input ready);
   modport sink (input valid, entry_index, out_pos_x, out_pos_y, out_vel_x, out_vel_y,
                 collided, last_result, output ready);
endinterface

// ===== src/particle_wall_and_collision_step.sv =====
// particle_wall_and_collision_step: particle table with wall bounce and pair collision
// depends on pwc_pkg, pwc_req_if, pwc_rsp_if, pwc_store and pwc_iter
//
//   channel   | direction | moves
//   ----------+-----------+---------------------------------------------
//   req_chan  | in        | one request: command, indices, load payload
//   rsp_chan  | out       | one entry result (two for a collide request)
//   csr_*     | in        | area_width / area_height register writes
//
// one request at a time; load passes ST_LOAD and ST_EA, read ST_RDA, ST_RDB and ST_EA, move
// ST_RDA, ST_RDB, ST_MOVE and ST_EA; collide with contact uses the shared bit-serial unit for
// one 32-step square root and four 64-step divides; without contact only the square root
// the result register lets the next request in while a result still waits
// reset is synchronous and resets control state and the area registers only; table entries are undefined
// until loaded
module particle_wall_and_collision_step #(
   parameter int NUM_PARTICLES = pwc_pkg::PWC_NUM_PARTICLES
) (
   input  logic                           clock,
   input  logic                           reset,
   pwc_req_if.sink                        req_chan,
   pwc_rsp_if.source                      rsp_chan,
   input  logic                           csr_we,
   input  logic [pwc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pwc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import pwc_pkg::*;

   localparam int ADDR_W = $clog2(NUM_PARTICLES);

   // control
   pwc_state_type    state_ff, state_in;
   logic             rsp_valid_ff;
   logic             out_load;
   logic             out_sel_b;
   logic [AREA_W-1:0] area_width_ff;
   logic [AREA_W-1:0] area_height_ff;
   logic             req_fire;

   // request and entry registers
   pwc_cmd_type      cmd_ff;
   logic [IDX_W-1:0] a_idx_ff, b_idx_ff;
   logic signed [31:0] a_px_ff, a_py_ff, a_vx_ff, a_vy_ff;
   logic signed [31:0] b_px_ff, b_py_ff, b_vx_ff, b_vy_ff;
   logic [MR_W-1:0]  a_m_ff, a_r_ff, b_m_ff, b_r_ff;

   // collision math
   logic             dx_neg_ff, dy_neg_ff, dvx_neg_ff, dvy_neg_ff;
   logic [31:0]      magdx_ff, magdy_ff, magdvx_ff, magdvy_ff;
   logic [31:0]      rsum_ff, msum_ff, d_ff;
   logic             d2nz_ff, hit_ff;
   logic [63:0]      sx_ff, gx_ff, gy_ff, prod_ff;
   logic [30:0]      qa_ff, qb_ff;
   logic [33:0]      t1x_ff, t1y_ff, t2x_ff, t2y_ff, ox_ff, oy_ff;

   // result register
   logic [IDX_W-1:0]   out_idx_ff;
   logic signed [31:0] out_px_ff, out_py_ff, out_vx_ff, out_vy_ff;
   logic               out_hit_ff, out_last_ff;

   // comb
   logic [31:0]      mul_a, mul_b;
   logic [31:0]      gap;
   logic [64:0]      d2_sum;
   logic [63:0]      d2;
   logic             hit_now;
   logic [63:0]      mv_x, mv_y;
   logic signed [32:0] dx, dy, dvx, dvy;
   logic signed [31:0] na_px, na_py, na_vx, na_vy, nb_px, nb_py, nb_vx, nb_vy;
   pwc_iter_req_type iter_req;
   pwc_iter_rsp_type iter_rsp;
   pwc_mem_ctl_type  mem_ctl;
   pwc_entry_type    mem_wdata, mem_rdata;
   logic [IDX_W-1:0] mem_idx;

   pwc_store #(.NUM_PARTICLES(NUM_PARTICLES)) u_store (
      .clock (clock),
      .addr  (ADDR_W'(mem_idx)),
      .ctl   (mem_ctl),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   pwc_iter u_iter (
      .clock (clock),
      .reset (reset),
      .req   (iter_req),
      .rsp   (iter_rsp)
   );

   assign req_fire       = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         area_width_ff  <= AREA_WIDTH_RESET;
         area_height_ff <= AREA_HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_AREA_WIDTH:  area_width_ff  <= csr_wdata;
            CSR_AREA_HEIGHT: area_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // differences of the captured pair
   assign dx  = 33'(a_px_ff) - 33'(b_px_ff);
   assign dy  = 33'(a_py_ff) - 33'(b_py_ff);
   assign dvx = 33'(a_vx_ff) - 33'(b_vx_ff);
   assign dvy = 33'(a_vy_ff) - 33'(b_vy_ff);

   // square sum saturates at all ones
   assign d2_sum  = {1'b0, sx_ff} + {1'b0, prod_ff};
   assign d2      = d2_sum[64] ? '1 : d2_sum[63:0];
   assign gap     = rsum_ff - d_ff;
   assign hit_now = (a_idx_ff != b_idx_ff) && d2nz_ff && (iter_rsp.result[31:0] <= rsum_ff);

   // move and bounce
   assign mv_x = pwc_bounce(a_px_ff, a_vx_ff, a_r_ff, area_width_ff);
   assign mv_y = pwc_bounce(a_py_ff, a_vy_ff, a_r_ff, area_height_ff);

   // elastic exchange and separation
   assign na_vx = pwc_adj(a_vx_ff, !dvx_neg_ff, t1x_ff);
   assign na_vy = pwc_adj(a_vy_ff, !dvy_neg_ff, t1y_ff);
   assign nb_vx = pwc_adj(b_vx_ff, dvx_neg_ff, t2x_ff);
   assign nb_vy = pwc_adj(b_vy_ff, dvy_neg_ff, t2y_ff);
   assign na_px = pwc_adj(a_px_ff, dx_neg_ff, ox_ff);
   assign na_py = pwc_adj(a_py_ff, dy_neg_ff, oy_ff);
   assign nb_px = pwc_adj(b_px_ff, !dx_neg_ff, ox_ff);
   assign nb_py = pwc_adj(b_py_ff, !dy_neg_ff, oy_ff);

   // shared multiplier operands; the product is registered and lands in the next cycle
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_SQX: begin mul_a = magdx_ff;  mul_b = magdx_ff; end
         ST_SQY: begin mul_a = magdy_ff;  mul_b = magdy_ff; end
         ST_M1:  begin mul_a = magdvx_ff; mul_b = {1'b0, qa_ff}; end
         ST_M2:  begin mul_a = magdvy_ff; mul_b = {1'b0, qa_ff}; end
         ST_M3:  begin mul_a = magdvx_ff; mul_b = {1'b0, qb_ff}; end
         ST_M4:  begin mul_a = magdvy_ff; mul_b = {1'b0, qb_ff}; end
         ST_M5:  begin mul_a = magdx_ff;  mul_b = gap; end
         ST_M6:  begin mul_a = magdy_ff;  mul_b = gap; end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // sequencer: next state, memory and iterative unit control
   always_comb begin
      state_in  = state_ff;
      out_load  = 1'b0;
      out_sel_b = 1'b0;
      mem_ctl   = '{wr_pv: 1'b0, wr_mr: 1'b0};
      mem_idx   = a_idx_ff;
      mem_wdata = '{pos: {mv_y[31:0], mv_x[31:0]}, vel: {mv_y[63:32], mv_x[63:32]},
                    mr: {1'b0, a_r_ff, 1'b0, a_m_ff}};
      iter_req  = '{start: 1'b0, mode: ITER_DIV, operand: '0, divisor: '0};
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (pwc_cmd_type'(req_chan.cmd) == CMD_LOAD) ? ST_LOAD : ST_RDA;
            end
         end
         ST_LOAD: begin
            mem_ctl   = '{wr_pv: 1'b1, wr_mr: 1'b1};
            mem_wdata = '{pos: {a_py_ff, a_px_ff}, vel: {a_vy_ff, a_vx_ff},
                          mr: {1'b0, a_r_ff, 1'b0, a_m_ff}};
            state_in  = ST_EA;
         end
         ST_RDA: state_in = ST_RDB;
         ST_RDB: begin
            mem_idx = b_idx_ff;
            unique case (cmd_ff)
               CMD_MOVE:    state_in = ST_MOVE;
               CMD_COLLIDE: state_in = ST_CAPB;
               default:     state_in = ST_EA;
            endcase
         end
         ST_CAPB: state_in = ST_DIFF;
         ST_MOVE: begin
            mem_ctl  = '{wr_pv: 1'b1, wr_mr: 1'b0};
            state_in = ST_EA;
         end
         ST_DIFF: state_in = ST_SQX;
         ST_SQX:  state_in = ST_SQY;
         ST_SQY:  state_in = ST_SUM;
         ST_SUM: begin
            iter_req = '{start: 1'b1, mode: ITER_SQRT, operand: d2, divisor: '0};
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            if (iter_rsp.done) begin
               state_in = hit_now ? ST_QA_GO : ST_EA;
            end
         end
         ST_QA_GO: begin
            iter_req = '{start: 1'b1, mode: ITER_DIV, operand: {3'b0, b_m_ff, 30'b0},
                         divisor: {1'b0, msum_ff}};
            state_in = ST_QA;
         end
         ST_QA: if (iter_rsp.done) state_in = ST_QB_GO;
         ST_QB_GO: begin
            iter_req = '{start: 1'b1, mode: ITER_DIV, operand: {3'b0, a_m_ff, 30'b0},
                         divisor: {1'b0, msum_ff}};
            state_in = ST_QB;
         end
         ST_QB: if (iter_rsp.done) state_in = ST_M1;
         ST_M1: state_in = ST_M2;
         ST_M2: state_in = ST_M3;
         ST_M3: state_in = ST_M4;
         ST_M4: state_in = ST_M5;
         ST_M5: state_in = ST_M6;
         ST_M6: state_in = ST_OX_GO;
         ST_OX_GO: begin
            iter_req = '{start: 1'b1, mode: ITER_DIV, operand: gx_ff, divisor: {d_ff, 1'b0}};
            state_in = ST_OX;
         end
         ST_OX: if (iter_rsp.done) state_in = ST_OY_GO;
         ST_OY_GO: begin
            iter_req = '{start: 1'b1, mode: ITER_DIV, operand: gy_ff,
                         divisor: {d_ff, 1'b0}};
            state_in = ST_OY;
         end
         ST_OY: if (iter_rsp.done) state_in = ST_WRA;
         ST_WRA: begin
            mem_ctl   = '{wr_pv: 1'b1, wr_mr: 1'b0};
            mem_wdata = '{pos: {na_py, na_px}, vel: {na_vy, na_vx},
                          mr: {1'b0, a_r_ff, 1'b0, a_m_ff}};
            state_in  = ST_WRB;
         end
         ST_WRB: begin
            mem_ctl   = '{wr_pv: 1'b1, wr_mr: 1'b0};
            mem_idx   = b_idx_ff;
            mem_wdata = '{pos: {nb_py, nb_px}, vel: {nb_vy, nb_vx},
                          mr: {1'b0, b_r_ff, 1'b0, b_m_ff}};
            state_in  = ST_EA;
         end
         ST_EA: begin
            // result register free or draining this cycle
            if (!rsp_valid_ff || rsp_chan.ready) begin
               out_load = 1'b1;
               state_in = (cmd_ff == CMD_COLLIDE) ? ST_EB : ST_IDLE;
            end
         end
         ST_EB: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               out_load  = 1'b1;
               out_sel_b = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd_ff   <= pwc_cmd_type'(req_chan.cmd);
               a_idx_ff <= pwc_mod_index(req_chan.first_index, NUM_PARTICLES);
               b_idx_ff <= pwc_mod_index(req_chan.second_index, NUM_PARTICLES);
               a_px_ff  <= req_chan.load_pos_x;
               a_py_ff  <= req_chan.load_pos_y;
               a_vx_ff  <= req_chan.load_vel_x;
               a_vy_ff  <= req_chan.load_vel_y;
               a_m_ff   <= req_chan.load_mass;
               a_r_ff   <= req_chan.load_radius;
               hit_ff   <= 1'b0;
            end
         end
         ST_RDB: begin
            a_px_ff <= mem_rdata.pos[31:0];
            a_py_ff <= mem_rdata.pos[63:32];
            a_vx_ff <= mem_rdata.vel[31:0];
            a_vy_ff <= mem_rdata.vel[63:32];
            a_m_ff  <= mem_rdata.mr[30:0];
            a_r_ff  <= mem_rdata.mr[62:32];
         end
         ST_CAPB: begin
            b_px_ff <= mem_rdata.pos[31:0];
            b_py_ff <= mem_rdata.pos[63:32];
            b_vx_ff <= mem_rdata.vel[31:0];
            b_vy_ff <= mem_rdata.vel[63:32];
            b_m_ff  <= mem_rdata.mr[30:0];
            b_r_ff  <= mem_rdata.mr[62:32];
         end
         ST_MOVE: begin
            a_px_ff <= mv_x[31:0];
            a_vx_ff <= mv_x[63:32];
            a_py_ff <= mv_y[31:0];
            a_vy_ff <= mv_y[63:32];
         end
         ST_DIFF: begin
            dx_neg_ff  <= dx[32];
            dy_neg_ff  <= dy[32];
            dvx_neg_ff <= dvx[32];
            dvy_neg_ff <= dvy[32];
            magdx_ff   <= dx[32] ? 32'(-dx) : dx[31:0];
            magdy_ff   <= dy[32] ? 32'(-dy) : dy[31:0];
            magdvx_ff  <= dvx[32] ? 32'(-dvx) : dvx[31:0];
            magdvy_ff  <= dvy[32] ? 32'(-dvy) : dvy[31:0];
            rsum_ff    <= {1'b0, a_r_ff} + {1'b0, b_r_ff};
            msum_ff    <= {1'b0, a_m_ff} + {1'b0, b_m_ff};
         end
         ST_SQY: sx_ff <= prod_ff;
         ST_SUM: d2nz_ff <= |d2;
         ST_SQRT: begin
            if (iter_rsp.done) begin
               d_ff   <= iter_rsp.result[31:0];
               hit_ff <= hit_now;
            end
         end
         // zero total mass leaves velocities alone
         ST_QA: if (iter_rsp.done) qa_ff <= (msum_ff == '0) ? '0 : iter_rsp.result[30:0];
         ST_QB: if (iter_rsp.done) qb_ff <= (msum_ff == '0) ? '0 : iter_rsp.result[30:0];
         ST_M2: t1x_ff <= prod_ff[62:29];
         ST_M3: t1y_ff <= prod_ff[62:29];
         ST_M4: t2x_ff <= prod_ff[62:29];
         ST_M5: t2y_ff <= prod_ff[62:29];
         ST_M6: gx_ff  <= prod_ff;
         // y numerator lands here and is held for the second divide
         ST_OX_GO: gy_ff <= prod_ff;
         ST_OX: if (iter_rsp.done) ox_ff <= pwc_clamp34(iter_rsp.result);
         ST_OY: if (iter_rsp.done) oy_ff <= pwc_clamp34(iter_rsp.result);
         ST_WRA: begin
            a_px_ff <= na_px;
            a_py_ff <= na_py;
            a_vx_ff <= na_vx;
            a_vy_ff <= na_vy;
         end
         ST_WRB: begin
            b_px_ff <= nb_px;
            b_py_ff <= nb_py;
            b_vx_ff <= nb_vx;
            b_vy_ff <= nb_vy;
         end
         default: ;
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (out_load) begin
         out_idx_ff  <= out_sel_b ? b_idx_ff : a_idx_ff;
         out_px_ff   <= out_sel_b ? b_px_ff : a_px_ff;
         out_py_ff   <= out_sel_b ? b_py_ff : a_py_ff;
         out_vx_ff   <= out_sel_b ? b_vx_ff : a_vx_ff;
         out_vy_ff   <= out_sel_b ? b_vy_ff : a_vy_ff;
         out_hit_ff  <= hit_ff;
         out_last_ff <= out_sel_b || (cmd_ff != CMD_COLLIDE);
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.entry_index = out_idx_ff;
   assign rsp_chan.out_pos_x   = out_px_ff;
   assign rsp_chan.out_pos_y   = out_py_ff;
   assign rsp_chan.out_vel_x   = out_vx_ff;
   assign rsp_chan.out_vel_y   = out_vy_ff;
   assign rsp_chan.collided    = out_hit_ff;
   assign rsp_chan.last_result = out_last_ff;
endmodule

// ===== src/pwc_store.sv =====
// pwc_store: particle table, three synchronous memories with one shared address
// depends on pwc_pkg
module pwc_store #(
   parameter int NUM_PARTICLES = pwc_pkg::PWC_NUM_PARTICLES
) (
   input  logic                                 clock,
   input  logic [$clog2(NUM_PARTICLES)-1:0]     addr,
   input  pwc_pkg::pwc_mem_ctl_type             ctl,
   input  pwc_pkg::pwc_entry_type               wdata,
   output pwc_pkg::pwc_entry_type               rdata
);
   import pwc_pkg::*;

   logic [63:0] pos_mem [NUM_PARTICLES];
   logic [63:0] vel_mem [NUM_PARTICLES];
   logic [63:0] mr_mem  [NUM_PARTICLES];
   logic [63:0] rd_pos_ff;
   logic [63:0] rd_vel_ff;
   logic [63:0] rd_mr_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_pv) begin
         pos_mem[addr] <= wdata.pos;
         vel_mem[addr] <= wdata.vel;
      end
      if (ctl.wr_mr) begin
         mr_mem[addr] <= wdata.mr;
      end
   end

   always_ff @(posedge clock) begin
      rd_pos_ff <= pos_mem[addr];
      rd_vel_ff <= vel_mem[addr];
      rd_mr_ff  <= mr_mem[addr];
   end

   assign rdata = '{pos: rd_pos_ff, vel: rd_vel_ff, mr: rd_mr_ff};
endmodule

// ===== src/pwc_iter.sv =====
// pwc_iter: shared bit-serial unit for square root (32 steps) and division (64 steps)
// depends on pwc_pkg
module pwc_iter (
   input  logic                       clock,
   input  logic                       reset,
   input  pwc_pkg::pwc_iter_req_type  req,
   output pwc_pkg::pwc_iter_rsp_type  rsp
);
   import pwc_pkg::*;

   logic              busy_ff;
   logic              done_ff;
   logic [6:0]        cnt_ff;
   pwc_iter_mode_type mode_ff;
   logic [63:0]       acc_ff;
   logic [34:0]       rem_ff;
   logic [63:0]       quo_ff;
   logic [32:0]       dvs_ff;
   logic [34:0]       rem_sh;
   logic [34:0]       trial;
   logic              take;

   always_comb begin
      if (mode_ff == ITER_SQRT) begin
         rem_sh = {rem_ff[32:0], acc_ff[63:62]};
         trial  = {quo_ff[32:0], 2'b01};
      end else begin
         rem_sh = {rem_ff[33:0], acc_ff[63]};
         trial  = {2'b00, dvs_ff};
      end
      take = (rem_sh >= trial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == 7'd1);
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= (req.mode == ITER_SQRT) ? 7'd32 : 7'd64;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 7'd1;
            if (cnt_ff == 7'd1) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         mode_ff <= req.mode;
         acc_ff  <= req.operand;
         dvs_ff  <= req.divisor;
         rem_ff  <= '0;
         quo_ff  <= '0;
      end else if (busy_ff) begin
         rem_ff <= take ? (rem_sh - trial) : rem_sh;
         quo_ff <= {quo_ff[62:0], take};
         acc_ff <= (mode_ff == ITER_SQRT) ? {acc_ff[61:0], 2'b00} : {acc_ff[62:0], 1'b0};
      end
   end

   assign rsp = '{done: done_ff, result: quo_ff};
endmodule

// ===== src/pwc_checker.sv =====
// pwc_checker: port-level checks of the particle step block, bound to the top level
// depends on pwc_pkg for field widths
module pwc_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [pwc_pkg::IDX_W-1:0]   rsp_entry_index,
   input logic [pwc_pkg::FIX_W-1:0]   rsp_out_pos_x,
   input logic                        rsp_collided,
   input logic                        rsp_last_result
);
   import pwc_pkg::*;

   // results are cleared by reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // one request at a time
   a_one_request: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_entry_index)
         && $stable(rsp_out_pos_x) && $stable(rsp_collided) && $stable(rsp_last_result))
      else $error("stalled result changed");

   // first result of a pair is followed at once by the second
   a_pair_second: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_result |=> rsp_valid && rsp_last_result)
      else $error("second result of a pair missing");
endmodule

bind particle_wall_and_collision_step pwc_checker u_pwc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_entry_index (rsp_chan.entry_index),
   .rsp_out_pos_x   (rsp_chan.out_pos_x),
   .rsp_collided    (rsp_chan.collided),
   .rsp_last_result (rsp_chan.last_result)
);
